FILE: hdl/lutf8_pkg.sv
// shared types and constants for the lenient utf-8 decoder
`default_nettype none

package lutf8_pkg;

   localparam int unsigned CpWidth    = 21;
   localparam int unsigned MaxResults = 4;

   localparam logic [CpWidth-1:0] ReplCp = 21'h00FFFD;

   localparam logic [7:0] Lead4Min = 8'hF0;
   localparam logic [7:0] Lead3Min = 8'hE0;
   localparam logic [7:0] Lead2Min = 8'hC0;

   localparam logic [1:0] ContTag = 2'b10;

   // sequence lengths
   localparam logic [2:0] Len1 = 3'd1;
   localparam logic [2:0] Len2 = 3'd2;
   localparam logic [2:0] Len3 = 3'd3;
   localparam logic [2:0] Len4 = 3'd4;

   // one decoded result
   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               is_replacement;
      logic               run_last;
      logic               string_done;
   } rsp_item_type;

   // pending sequence state
   typedef struct packed {
      logic [7:0] lead;
      logic [7:0] held1;
      logic [7:0] held2;
      logic [1:0] held_count;
      logic [2:0] expected_length;
   } seq_state_type;

   function automatic rsp_item_type make_item(logic [CpWidth-1:0] cp, logic rep);
      rsp_item_type item;
      item.code_point     = cp;
      item.is_replacement = rep;
      item.run_last       = 1'b0;
      item.string_done    = 1'b0;
      return item;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/lutf8_decode.sv
// single-pass decode of one byte against the pending sequence state
`default_nettype none

module lutf8_decode (
   input  wire logic [7:0]                 data_byte,
   input  wire logic                       string_end,
   input  wire lutf8_pkg::seq_state_type   state_cur,
   output lutf8_pkg::seq_state_type        state_next,
   output lutf8_pkg::rsp_item_type         items [lutf8_pkg::MaxResults],
   output logic [2:0]                      item_count
);

   logic                            cont;
   logic [2:0]                      fresh_len;
   logic                            fresh;
   logic [2:0]                      n;
   logic [lutf8_pkg::CpWidth-1:0]   assembled;
   logic [lutf8_pkg::CpWidth-1:0]   byte_cp;

   assign cont    = (data_byte[7:6] == lutf8_pkg::ContTag);
   assign byte_cp = {13'd0, data_byte};

   always_comb begin
      if (data_byte >= lutf8_pkg::Lead4Min) begin
         fresh_len = lutf8_pkg::Len4;
      end else if (data_byte >= lutf8_pkg::Lead3Min) begin
         fresh_len = lutf8_pkg::Len3;
      end else if (data_byte >= lutf8_pkg::Lead2Min) begin
         fresh_len = lutf8_pkg::Len2;
      end else begin
         fresh_len = lutf8_pkg::Len1;
      end
   end

   // completion always happens with held_count one below the length
   always_comb begin
      case (state_cur.expected_length)
         lutf8_pkg::Len4: begin
            assembled = {state_cur.lead[2:0], state_cur.held1[5:0],
                         state_cur.held2[5:0], data_byte[5:0]};
         end
         lutf8_pkg::Len3: begin
            assembled = {5'd0, state_cur.lead[3:0], state_cur.held1[5:0],
                         data_byte[5:0]};
         end
         default: begin
            assembled = {10'd0, state_cur.lead[4:0], data_byte[5:0]};
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < lutf8_pkg::MaxResults; i++) begin
         items[i] = '0;
      end
      n          = 3'd0;
      fresh      = 1'b0;
      state_next = state_cur;

      if (state_cur.held_count == 2'd0) begin
         fresh = 1'b1;
      end else if (!cont) begin
         // bad continuation: replacement, replay held continuations, restart on this byte
         items[n[1:0]] = lutf8_pkg::make_item(lutf8_pkg::ReplCp, 1'b1);
         n = n + 3'd1;
         if (state_cur.held_count >= 2'd2) begin
            items[n[1:0]] = lutf8_pkg::make_item({13'd0, state_cur.held1}, 1'b0);
            n = n + 3'd1;
         end
         if (state_cur.held_count == 2'd3) begin
            items[n[1:0]] = lutf8_pkg::make_item({13'd0, state_cur.held2}, 1'b0);
            n = n + 3'd1;
         end
         state_next.held_count      = 2'd0;
         state_next.expected_length = lutf8_pkg::Len1;
         fresh = 1'b1;
      end else if ({1'b0, state_cur.held_count} + 3'd1 >= state_cur.expected_length) begin
         items[n[1:0]] = lutf8_pkg::make_item(assembled, 1'b0);
         n = n + 3'd1;
         state_next.held_count      = 2'd0;
         state_next.expected_length = lutf8_pkg::Len1;
      end else if (string_end) begin
         // truncated sequence: replacement, held continuations, then this byte
         items[n[1:0]] = lutf8_pkg::make_item(lutf8_pkg::ReplCp, 1'b1);
         n = n + 3'd1;
         if (state_cur.held_count >= 2'd2) begin
            items[n[1:0]] = lutf8_pkg::make_item({13'd0, state_cur.held1}, 1'b0);
            n = n + 3'd1;
         end
         if (state_cur.held_count == 2'd3) begin
            items[n[1:0]] = lutf8_pkg::make_item({13'd0, state_cur.held2}, 1'b0);
            n = n + 3'd1;
         end
         items[n[1:0]] = lutf8_pkg::make_item(byte_cp, 1'b0);
         n = n + 3'd1;
         state_next.held_count      = 2'd0;
         state_next.expected_length = lutf8_pkg::Len1;
      end else begin
         if (state_cur.held_count[0]) begin
            state_next.held1 = data_byte;
         end else if (state_cur.held_count[1]) begin
            state_next.held2 = data_byte;
         end else begin
            state_next.lead = data_byte;
         end
         state_next.held_count = state_cur.held_count + 2'd1;
      end

      if (fresh) begin
         if (fresh_len == lutf8_pkg::Len1) begin
            items[n[1:0]] = lutf8_pkg::make_item(byte_cp, 1'b0);
            n = n + 3'd1;
         end else if (string_end) begin
            items[n[1:0]] = lutf8_pkg::make_item(lutf8_pkg::ReplCp, 1'b1);
            n = n + 3'd1;
         end else begin
            state_next.lead            = data_byte;
            state_next.held_count      = 2'd1;
            state_next.expected_length = fresh_len;
         end
      end

      if (string_end) begin
         state_next.held_count      = 2'd0;
         state_next.expected_length = lutf8_pkg::Len1;
      end

      if (n != 3'd0) begin
         items[n[1:0] - 2'd1].run_last    = 1'b1;
         items[n[1:0] - 2'd1].string_done = string_end;
      end

      item_count = n;
   end

endmodule

`default_nettype wire

FILE: hdl/lenient_utf8_decoder_top.sv
// top level of the lenient utf-8 decoder: input register, decode, result buffer
//
//   channel | dir | tdata            | tuser                             | tlast
//   req_    | in  | [7:0] data_byte  | -                                 | string_end
//   rsp_    | out | [20:0] code_point| [0] is_replacement [1] string_done| run_last
//
// a byte is held in the input register, then decoded and loaded into the
// result buffer, from which its first result is presented
// one byte per cycle while each byte gives zero or one result and rsp_tready is
// high; a byte that gives more results holds the input register while the buffer
// drains one result per cycle
// reset clears the pending sequence, the input register and the result buffer
// a stall on rsp_tready backs up through the buffer into req_tready
`default_nettype none

module lenient_utf8_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // string_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [1:0]       rsp_tuser,   // [0] is_replacement, [1] string_done
   output logic             rsp_tlast    // run_last
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_end_ff, in_end_in;

   // pending sequence: payload bytes and control
   logic [7:0]  lead_ff, lead_in;
   logic [7:0]  held1_ff, held1_in;
   logic [7:0]  held2_ff, held2_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic [2:0]  exp_len_ff, exp_len_in;

   // result buffer
   lutf8_pkg::rsp_item_type res_ff [lutf8_pkg::MaxResults];
   lutf8_pkg::rsp_item_type res_in [lutf8_pkg::MaxResults];
   logic [1:0]  res_idx_ff, res_idx_in;
   logic [2:0]  res_left_ff, res_left_in;

   lutf8_pkg::seq_state_type state_cur, state_next;
   lutf8_pkg::rsp_item_type  dec_items [lutf8_pkg::MaxResults];
   logic [2:0]               dec_count;

   logic req_xact, rsp_xact, buf_free, load;
   lutf8_pkg::rsp_item_type  head;

   assign req_xact = req_tvalid && req_tready;
   assign rsp_xact = rsp_tvalid && rsp_tready;

   // buffer can take a new burst when it is empty or its last result goes out this cycle
   assign buf_free   = (res_left_ff == 3'd0) || (res_left_ff == 3'd1 && rsp_tready);
   assign load       = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || buf_free;

   assign state_cur.lead            = lead_ff;
   assign state_cur.held1           = held1_ff;
   assign state_cur.held2           = held2_ff;
   assign state_cur.held_count      = held_count_ff;
   assign state_cur.expected_length = exp_len_ff;

   lutf8_decode u_decode (
      .data_byte  (in_byte_ff),
      .string_end (in_end_ff),
      .state_cur  (state_cur),
      .state_next (state_next),
      .items      (dec_items),
      .item_count (dec_count)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_xact) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_end_in   = req_tlast;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      lead_in       = lead_ff;
      held1_in      = held1_ff;
      held2_in      = held2_ff;
      held_count_in = held_count_ff;
      exp_len_in    = exp_len_ff;
      if (load) begin
         lead_in       = state_next.lead;
         held1_in      = state_next.held1;
         held2_in      = state_next.held2;
         held_count_in = state_next.held_count;
         exp_len_in    = state_next.expected_length;
      end
   end

   always_comb begin
      res_in      = res_ff;
      res_idx_in  = res_idx_ff;
      res_left_in = res_left_ff;
      if (load) begin
         res_in      = dec_items;
         res_idx_in  = 2'd0;
         res_left_in = dec_count;
      end else if (rsp_xact) begin
         res_idx_in  = res_idx_ff + 2'd1;
         res_left_in = res_left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_count_ff <= 2'd0;
         exp_len_ff    <= lutf8_pkg::Len1;
         res_idx_ff    <= 2'd0;
         res_left_ff   <= 3'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         held_count_ff <= held_count_in;
         exp_len_ff    <= exp_len_in;
         res_idx_ff    <= res_idx_in;
         res_left_ff   <= res_left_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      lead_ff    <= lead_in;
      held1_ff   <= held1_in;
      held2_ff   <= held2_in;
      res_ff     <= res_in;
   end

   assign head       = res_ff[res_idx_ff];
   assign rsp_tvalid = (res_left_ff != 3'd0);
   assign rsp_tdata  = {3'd0, head.code_point};
   assign rsp_tuser  = {head.string_done, head.is_replacement};
   assign rsp_tlast  = head.run_last;

   // buffer never holds more than one byte's worth of results
   assert property (@(posedge clock) disable iff (reset)
      res_left_ff <= 3'd4)
      else $error("result buffer count out of range");

   // a pending sequence is always shorter than its expected length
   assert property (@(posedge clock) disable iff (reset)
      (held_count_ff != 2'd0) |->
         (exp_len_ff >= lutf8_pkg::Len2 && {1'b0, held_count_ff} < exp_len_ff))
      else $error("pending sequence state inconsistent");

   // idle sequence state carries length one
   assert property (@(posedge clock) disable iff (reset)
      (held_count_ff == 2'd0) |-> (exp_len_ff == lutf8_pkg::Len1))
      else $error("idle state with stale length");

   // a decoded burst with results shows up on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (load && dec_count != 3'd0) |=> rsp_tvalid)
      else $error("decoded results not presented");

   // string end always leaves no pending sequence behind
   assert property (@(posedge clock) disable iff (reset)
      (load && in_end_ff) |=> (held_count_ff == 2'd0))
      else $error("sequence pending after string end");

endmodule

`default_nettype wire

FILE: test/tb_lenient_utf8_decoder_top.sv
// self-checking testbench for the lenient utf-8 decoder, directed strings then random strings
`timescale 1ns / 1ps

module tb_lenient_utf8_decoder_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int BYTE_TARGET = 370;
   localparam int CP_WIDTH    = lutf8_pkg::CpWidth;

   // one byte of the input stream together with its end-of-string flag
   typedef struct packed {
      logic [7:0] data_byte;
      logic       string_end;
   } utf8_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic        req_tlast = 1'b0; // string_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [20:0] code_point, [23:21] zero
   logic [1:0]  rsp_tuser;        // [0] is_replacement, [1] string_done
   logic        rsp_tlast;        // run_last

   lenient_utf8_decoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // bytes still to send, and the code points the decoder still owes us
   utf8_byte_type           byte_stream[$];
   lutf8_pkg::rsp_item_type pending_code_points[$];
   lutf8_pkg::rsp_item_type decode_run[$];
   logic [7:0]              text_bytes[$];

   // decoder state as the model of the block sees it
   logic [7:0] seq_lead;
   logic [7:0] seq_cont [1:2];
   logic [1:0] seq_count;
   logic [2:0] seq_len;

   int total_bytes = 0;
   int string_count = 0;
   int accepted_count = 0;
   int results_seen = 0;
   int replacements_seen = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   utf8_byte_type next_byte;
   lutf8_pkg::rsp_item_type want;

   // ------------------------------------------------------------------
   // decode model
   // ------------------------------------------------------------------
   function void add_cp(logic [CP_WIDTH-1:0] cp, logic rep);
      lutf8_pkg::rsp_item_type r;
      r.code_point     = cp;
      r.is_replacement = rep;
      r.run_last       = 1'b0;
      r.string_done    = 1'b0;
      decode_run = {decode_run, r};
   endfunction

   function void clear_sequence();
      seq_count = '0;
      seq_len   = lutf8_pkg::Len1;
   endfunction

   // continuation bytes held so far come back one code point each; the lead does not
   function void replay_held();
      for (int i = 1; i < int'(seq_count); i++)
         add_cp(CP_WIDTH'(seq_cont[i]), 1'b0);
   endfunction

   // a byte seen with no sequence pending: plain byte, or a lead that opens one
   function void start_byte(logic [7:0] b, logic last);
      logic [2:0] len;
      if (b >= lutf8_pkg::Lead4Min) len = lutf8_pkg::Len4;
      else if (b >= lutf8_pkg::Lead3Min) len = lutf8_pkg::Len3;
      else if (b >= lutf8_pkg::Lead2Min) len = lutf8_pkg::Len2;
      else len = lutf8_pkg::Len1;
      if (len == lutf8_pkg::Len1) begin
         add_cp(CP_WIDTH'(b), 1'b0);
      end else if (last) begin
         // a lead as the last byte of the string can never complete
         add_cp(lutf8_pkg::ReplCp, 1'b1);
      end else begin
         seq_lead  = b;
         seq_count = 2'd1;
         seq_len   = len;
      end
   endfunction

   function logic [CP_WIDTH-1:0] join_code_point(logic [7:0] b);
      logic [31:0] cp;
      // leads 0xf8 and up count as 4-byte leads with their low three bits kept
      case (seq_len)
         lutf8_pkg::Len4: cp = 32'(seq_lead & 8'h07);
         lutf8_pkg::Len3: cp = 32'(seq_lead & 8'h0F);
         default:         cp = 32'(seq_lead & 8'h1F);
      endcase
      for (int i = 1; i < int'(seq_count); i++)
         cp = (cp << 6) | 32'(seq_cont[i][5:0]);
      cp = (cp << 6) | 32'(b[5:0]);
      return cp[CP_WIDTH-1:0];
   endfunction

   // works out the code points one accepted byte gives and queues them
   function void decode_utf8_byte(logic [7:0] b, logic last);
      decode_run.delete();
      if (seq_count == 2'd0) begin
         start_byte(b, last);
      end else if (b[7:6] != lutf8_pkg::ContTag) begin
         // bad continuation: replacement, held continuations, then the byte afresh
         add_cp(lutf8_pkg::ReplCp, 1'b1);
         replay_held();
         clear_sequence();
         start_byte(b, last);
      end else if (int'(seq_count) + 1 >= int'(seq_len)) begin
         add_cp(join_code_point(b), 1'b0);
         clear_sequence();
      end else if (last) begin
         // string ends inside a sequence: replacement, then every continuation as itself
         add_cp(lutf8_pkg::ReplCp, 1'b1);
         replay_held();
         clear_sequence();
         add_cp(CP_WIDTH'(b), 1'b0);
      end else begin
         seq_cont[seq_count] = b;
         seq_count = seq_count + 2'd1;
      end
      if (last) clear_sequence();
      if (decode_run.size() != 0) begin
         decode_run[decode_run.size()-1].run_last    = 1'b1;
         decode_run[decode_run.size()-1].string_done = last;
      end
      foreach (decode_run[i]) pending_code_points = {pending_code_points, decode_run[i]};
   endfunction

   // ------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------
   // moves text_bytes into the send queue as one string, last byte flagged
   function void queue_string();
      utf8_byte_type item;
      foreach (text_bytes[i]) begin
         item.data_byte  = text_bytes[i];
         item.string_end = (i == text_bytes.size() - 1);
         byte_stream = {byte_stream, item};
      end
      total_bytes  += text_bytes.size();
      string_count += 1;
      text_bytes.delete();
   endfunction

   // one sequence of seq_bytes bytes with random payload, cut after sent_bytes
   function void add_sequence(int seq_bytes, int sent_bytes);
      logic [7:0] lead_b;
      case (seq_bytes)
         1:       lead_b = 8'($urandom_range(0, 127));
         2:       lead_b = 8'hC0 | 8'($urandom_range(0, 31));
         3:       lead_b = 8'hE0 | 8'($urandom_range(0, 15));
         default: lead_b = 8'hF0 | 8'($urandom_range(0, 15));  // 0xf8-0xff included
      endcase
      text_bytes = {text_bytes, lead_b};
      for (int i = 1; i < sent_bytes; i++)
         text_bytes = {text_bytes, 8'h80 | 8'($urandom_range(0, 63))};
   endfunction

   // ------------------------------------------------------------------
   // sender: drives the request channel, predicts on each accepted transaction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         clear_sequence();
      end else begin
         // results trail acceptance through the input register and the result buffer, so the
         // expectation is always queued before the monitor looks for it
         if (req_tvalid && req_tready) begin
            decode_utf8_byte(req_tdata, req_tlast);
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            // idle with a 6 percent chance, never in the quiet window
            if (byte_stream.size() != 0 &&
                !($urandom_range(0, 99) < 6 && !(accepted_count >= 150 && accepted_count < 250)))
            begin
               next_byte = byte_stream.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_byte.data_byte;
               req_tlast  <= next_byte.string_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off early in the run while the sender keeps offering,
   // so the result buffer fills and back-pressure reaches req_tready
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_count >= 40) begin
         hold_left <= 48;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ------------------------------------------------------------------
   // receiver: random stalls, checks each result transaction in order
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen += 1;
            if (rsp_tuser[0]) replacements_seen += 1;
            if (pending_code_points.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: cp %h rep %b last %b done %b",
                           rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
               mismatch_count += 1;
            end else begin
               want = pending_code_points.pop_front();
               // padding above the code point must stay zero
               if (rsp_tdata != {3'b000, want.code_point} ||
                   rsp_tuser[0] != want.is_replacement ||
                   rsp_tlast != want.run_last ||
                   rsp_tuser[1] != want.string_done) begin
                  if (mismatch_count < 10)
                     $display("mismatch at result %0d: expected cp %h rep %b last %b done %b, got cp %h rep %b last %b done %b",
                              results_seen, want.code_point, want.is_replacement,
                              want.run_last, want.string_done,
                              rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
                  mismatch_count += 1;
               end
            end
         end
         rsp_tready <= (hold_left == 0) &&
                       !($urandom_range(0, 99) < 6 && !(results_seen >= 150 && results_seen < 250));
      end
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int pick;
      int seq_bytes;
      int symbols;

      // plain bytes at both ends of the ascii range and a lone continuation
      text_bytes = '{8'h00, 8'h7F, 8'h80};             queue_string();
      // valid 2, 3 and 4 byte sequences
      text_bytes = '{8'hC3, 8'hA9};                     queue_string();
      text_bytes = '{8'hE2, 8'h82, 8'hAC};              queue_string();
      text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};       queue_string();
      // 0xff as a 4-byte lead, all payload bits set: largest code point
      text_bytes = '{8'hFF, 8'hBF, 8'hBF, 8'hBF};       queue_string();
      // lead byte as the last byte of the string
      text_bytes = '{8'hC0};                            queue_string();
      // bad continuation that is a plain byte
      text_bytes = '{8'hC3, 8'h41};                     queue_string();
      // bad continuation after a lead and two held continuations that is itself a lead at string end
      text_bytes = '{8'hF0, 8'h80, 8'h80, 8'hC2};       queue_string();
      // valid continuation but the string ends before the sequence completes
      text_bytes = '{8'hE2, 8'h82};                     queue_string();
      // bad continuation that opens a new sequence which then completes
      text_bytes = '{8'hE2, 8'hC3, 8'hA9};              queue_string();

      // random strings: mostly well-formed sequences, some cut short, some noise
      while (total_bytes < BYTE_TARGET) begin
         symbols = $urandom_range(1, 6);
         for (int s = 0; s < symbols; s++) begin
            pick = $urandom_range(0, 99);
            seq_bytes = $urandom_range(1, 4);
            if (pick < 70) begin
               add_sequence(seq_bytes, seq_bytes);
            end else if (pick < 85) begin
               seq_bytes = $urandom_range(2, 4);
               add_sequence(seq_bytes, $urandom_range(1, seq_bytes - 1));
            end else begin
               text_bytes = {text_bytes, 8'($urandom_range(0, 255))};
            end
         end
         queue_string();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_bytes) @(posedge clock);
      while (pending_code_points.size() != 0) @(posedge clock);
      // wait on so that any stray result past the last one is caught
      repeat (8) @(posedge clock);

      $display("sent %0d bytes in %0d strings, including truncated and malformed sequences",
               total_bytes, string_count);
      $display("checked %0d code points, %0d of them replacements, %0d mismatches",
               results_seen, replacements_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
